### hdl/tvwb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvwb_pkg
// Shared types and constants of the timestamped value window buffer.
// ----------------------------------------------------------------------------
package tvwb_pkg;
  localparam int Depth     = 32;
  localparam int PtrBits   = $clog2(Depth);
  localparam int CntBits   = $clog2(Depth + 1);
  localparam int ValueBits = 32;
  localparam int TimeBits  = 32;
  localparam int SpanBits  = 20;
  localparam int StatBits  = 3;
  localparam int QDepth    = 2;

  localparam logic [StatBits-1:0] ST_SEGMENT  = 3'd0;
  localparam logic [StatBits-1:0] ST_APPENDED = 3'd1;
  localparam logic [StatBits-1:0] ST_REPLACED = 3'd2;
  localparam logic [StatBits-1:0] ST_OUTORDER = 3'd3;
  localparam logic [StatBits-1:0] ST_DROPPED  = 3'd4;

  localparam logic [TimeBits-1:0] MIN_TIME = {1'b1, {(TimeBits-1){1'b0}}};
  localparam logic [SpanBits-1:0] DUR_MAX  = '1;
  localparam logic [0:0] REG_INITIAL_VALUE = 1'b0;

  typedef struct packed {
    logic                        action;
    logic signed [TimeBits-1:0]  time_req;
    logic [SpanBits-1:0]         span;
    logic signed [ValueBits-1:0] value;
  } req_t;

  typedef struct packed {
    logic [SpanBits-1:0]         duration;
    logic signed [ValueBits-1:0] value_out;
    logic [StatBits-1:0]         status;
    logic                        last;
  } res_t;
endpackage

### hdl/tvwb_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvwb_stream_if
// Valid/ready channel that carries one payload word.
// ----------------------------------------------------------------------------
interface tvwb_stream_if #(parameter int Width = 8);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/timestamped_value_window_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_value_window_buffer
// Ring of (start time, value) entries, kept in arrival order, with window queries.
// ----------------------------------------------------------------------------
// Requests enter on the in channel: an append adds an entry (dropped if the
// ring is full) or replaces the newest one, and answers with one status
// result; a query for [time_req, time_req + span) answers with one segment per
// crossed interval, the final one marked by last. Results leave on out_ch.
// A two-entry request queue lets the sender run ahead of the engine.
// A query scans entries one at a time, bounded by the 32-entry ring, and
// then emits its segments; each step waits on the single read port of the
// entry RAMs.
// Reset empties the ring and clears initial_value; the first request seeds
// a sentinel at the minimum time carrying initial_value.
// When the receiver stalls, the engine holds its result register and waits.
// initial_value is written over the APB port at address 0.
// ----------------------------------------------------------------------------
module timestamped_value_window_buffer (
  input  logic        clk,
  input  logic        rst,
  tvwb_stream_if.sink   in_ch,
  tvwb_stream_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tvwb_pkg::*;

  logic signed [ValueBits-1:0] initial_value;
  logic q_valid;
  logic q_pop;
  req_t q_req;
  req_t in_req;
  res_t out_res;

  assign pready = 1'b1;
  assign prdata = (paddr == {REG_INITIAL_VALUE, 1'b0}) ? 32'(initial_value) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_value <= '0;
    end else if (psel && penable && pwrite && paddr == {REG_INITIAL_VALUE, 1'b0}) begin
      initial_value <= pwdata;
    end
  end

  assign in_req = in_ch.data;
  assign out_ch.data = out_res;

  tvwb_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_req(in_req), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
  );

  tvwb_engine u_engine (
    .clk(clk), .rst(rst), .initial_value(initial_value),
    .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(out_res)
  );
endmodule

### hdl/tvwb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvwb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tvwb_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/tvwb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvwb_front
// Accepts requests and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
module tvwb_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tvwb_pkg::req_t in_req,
  output logic          q_valid,
  input  logic          q_pop,
  output tvwb_pkg::req_t q_req
);
  import tvwb_pkg::*;

  req_t slots [QDepth];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  logic push;

  assign in_ready = (fill != 2'(QDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_req    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_req;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end
endmodule

### hdl/tvwb_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvwb_engine
// Carries out appends and window queries on the entry ring.
// ----------------------------------------------------------------------------
module tvwb_engine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [tvwb_pkg::ValueBits-1:0] initial_value,
  input  logic                                  q_valid,
  output logic                                  q_pop,
  input  tvwb_pkg::req_t                        q_req,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output tvwb_pkg::res_t                        out_res
);
  import tvwb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_BACK  = 7'b0000010,
    S_APPL  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_SREAD = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  req_t   req;
  logic [PtrBits-1:0] head;
  logic [CntBits-1:0] count;
  logic [CntBits-1:0] idx;
  logic [CntBits-1:0] s_pos;
  logic signed [TimeBits+1:0] cur;
  logic has_next;
  logic [1:0] rd_wait;

  logic                 t_we;
  logic [PtrBits-1:0]   waddr;
  logic [TimeBits-1:0]  wtime;
  logic [ValueBits-1:0] wval;
  logic                 v_we;
  logic [PtrBits-1:0]   raddr;
  logic [TimeBits-1:0]  rtime;
  logic [ValueBits-1:0] rval;
  logic [ValueBits-1:0] cur_val;

  logic [CntBits-1:0] n_eff;
  logic               seeding;
  logic [PtrBits-1:0] head_eff;
  logic signed [TimeBits+1:0] end_t;
  logic signed [TimeBits+1:0] rtime_x;
  logic signed [TimeBits+1:0] dur_raw;
  logic [SpanBits-1:0] dur_sat;

  tvwb_ram #(.Width(TimeBits), .Depth(Depth)) u_times (
    .clk(clk), .we(t_we), .waddr(waddr), .wdata(wtime), .raddr(raddr), .rdata(rtime)
  );
  tvwb_ram #(.Width(ValueBits), .Depth(Depth)) u_values (
    .clk(clk), .we(v_we), .waddr(waddr), .wdata(wval), .raddr(raddr), .rdata(rval)
  );

  assign seeding  = (count == '0);
  assign n_eff    = seeding ? CntBits'(1) : count;
  assign head_eff = seeding ? '0 : head;
  assign end_t    = (TimeBits+2)'(req.time_req) + (TimeBits+2)'($signed({1'b0, req.span}));
  assign rtime_x  = (TimeBits+2)'($signed(rtime));
  assign q_pop    = (state == S_IDLE) && q_valid;

  always_comb begin
    dur_raw = (has_next && rtime_x < end_t) ? rtime_x - cur : end_t - cur;
    if (dur_raw < 0) begin
      dur_sat = '0;
    end else if (dur_raw > (TimeBits+2)'(DUR_MAX)) begin
      dur_sat = DUR_MAX;
    end else begin
      dur_sat = dur_raw[SpanBits-1:0];
    end
  end

  always_comb begin
    t_we  = 1'b0;
    v_we  = 1'b0;
    waddr = '0;
    wtime = MIN_TIME;
    wval  = initial_value;
    raddr = head_eff + PtrBits'(idx);
    if (state == S_IDLE && q_valid && seeding) begin
      t_we = 1'b1;
      v_we = 1'b1;
    end
    if (state == S_BACK) begin
      raddr = head_eff + PtrBits'(n_eff - CntBits'(1));
    end
    if (state == S_APPL) begin
      wval = req.value;
      if (rtime == req.time_req) begin
        v_we  = 1'b1;
        waddr = head_eff + PtrBits'(n_eff - CntBits'(1));
      end else if (n_eff < CntBits'(Depth)) begin
        t_we  = 1'b1;
        v_we  = 1'b1;
        waddr = head_eff + PtrBits'(n_eff);
        wtime = req.time_req;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            req <= q_req;
            if (seeding) begin
              head  <= '0;
              count <= CntBits'(1);
            end
            idx     <= '0;
            rd_wait <= 2'd0;
            state   <= q_req.action ? S_SCAN : S_BACK;
          end
        end
        S_BACK: begin
          state <= S_APPL;
        end
        S_APPL: begin
          out_res.duration  <= '0;
          out_res.value_out <= req.value;
          out_res.last      <= 1'b1;
          if (rtime == req.time_req) begin
            out_res.status <= ST_REPLACED;
          end else if (n_eff >= CntBits'(Depth)) begin
            out_res.status <= ST_DROPPED;
          end else begin
            out_res.status <= ($signed(req.time_req) < $signed(rtime)) ? ST_OUTORDER
                                                                        : ST_APPENDED;
            count <= count + CntBits'(1);
          end
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_SCAN: begin
          // Read address idx issued this cycle; data arrives next cycle.
          if (rd_wait == 2'd0) begin
            rd_wait <= 2'd1;
          end else if (idx < n_eff && !($signed(req.time_req) < $signed(rtime))) begin
            idx     <= idx + CntBits'(1);
            rd_wait <= 2'd0;
          end else begin
            s_pos   <= (idx == '0) ? '0 : idx - CntBits'(1);
            idx     <= (idx == '0) ? '0 : idx - CntBits'(1);
            cur     <= (TimeBits+2)'(req.time_req);
            rd_wait <= 2'd0;
            state   <= S_SREAD;
          end
        end
        S_SREAD: begin
          // Fetch the value of entry idx, then the time of entry idx + 1.
          if (out_ready) begin
            out_valid <= 1'b0;
          end
          if (rd_wait == 2'd0) begin
            rd_wait <= 2'd1;
          end else begin
            cur_val  <= rval;
            rd_wait  <= 2'd0;
            has_next <= (idx + CntBits'(1) < n_eff);
            if (idx + CntBits'(1) < n_eff) begin
              idx <= idx + CntBits'(1);
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            if (has_next && rd_wait == 2'd0) begin
              rd_wait   <= 2'd1;
              out_valid <= 1'b0;
            end else begin
              rd_wait <= 2'd0;
              out_res.duration  <= dur_sat;
              out_res.value_out <= cur_val;
              out_res.status    <= ST_SEGMENT;
              out_valid         <= 1'b1;
              if (has_next && rtime_x < end_t) begin
                cur   <= rtime_x;
                out_res.last <= 1'b0;
                state <= S_SREAD;
              end else begin
                out_res.last <= 1'b1;
                if (s_pos > CntBits'(1)) begin
                  head  <= head + PtrBits'(s_pos - CntBits'(1));
                  count <= count - (s_pos - CntBits'(1));
                end
                state <= S_OUT;
              end
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### bench/timestamped_value_window_buffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_value_window_buffer_tb
// Self-checking bench for the timestamped value window buffer. A scoreboard
// class mirrors the entry ring, predicts the status or segments that every
// accepted request causes, and compares each result in order. Directed
// requests cover replace, out-of-order, full-ring drop and early queries;
// random phases under bursty input, output stalls and several initial values
// follow.
// ----------------------------------------------------------------------------
module timestamped_value_window_buffer_tb;
  import tvwb_pkg::*;

  class window_scoreboard;
    logic signed [TimeBits-1:0] ring_time [Depth];
    logic [ValueBits-1:0] ring_value [Depth];
    int head;
    int count;
    logic [ValueBits-1:0] init_value;
    res_t pending [$];
    int mismatches;

    function new();
      head = 0;
      count = 0;
      init_value = '0;
      mismatches = 0;
    endfunction

    function int at(int i);
      return (head + i) % Depth;
    endfunction

    function void push_seg(longint dur, logic [ValueBits-1:0] v, logic [StatBits-1:0] st);
      res_t r;
      if (dur < 0) dur = 0;
      if (dur > longint'(DUR_MAX)) dur = longint'(DUR_MAX);
      r.duration = dur[SpanBits-1:0];
      r.value_out = v;
      r.status = st;
      r.last = 1'b0;
      pending.push_back(r);
    endfunction

    function void note_request(req_t q);
      longint t, stop, cur, nt;
      int s, idx, k, back;
      logic [StatBits-1:0] st;
      if (count == 0) begin
        head = 0;
        ring_time[0] = MIN_TIME;
        ring_value[0] = init_value;
        count = 1;
      end
      t = longint'(q.time_req);
      if (q.action == 1'b0) begin
        back = at(count - 1);
        if (longint'(ring_time[back]) == t) begin
          ring_value[back] = q.value;
          st = ST_REPLACED;
        end else if (count >= Depth) begin
          st = ST_DROPPED;
        end else begin
          st = (t < longint'(ring_time[back])) ? ST_OUTORDER : ST_APPENDED;
          ring_time[at(count)] = q.time_req;
          ring_value[at(count)] = q.value;
          count++;
        end
        push_seg(0, q.value, st);
        pending[$].last = 1'b1;
      end else begin
        stop = t + longint'(q.span);
        cur = t;
        k = 0;
        s = 0;
        while (s < count && !(t < longint'(ring_time[at(s)]))) s++;
        s -= 1;
        if (s < 0) s = 0;
        for (idx = s; idx < count - 1; idx++) begin
          nt = longint'(ring_time[at(idx + 1)]);
          if (nt < stop) begin
            push_seg(nt - cur, ring_value[at(idx)], ST_SEGMENT);
            k++;
          end else begin
            push_seg(stop - cur, ring_value[at(idx)], ST_SEGMENT);
            k++;
            break;
          end
          cur = nt;
        end
        if (idx == count - 1) begin
          if (k > 0) cur = longint'(ring_time[at(count - 1)]);
          push_seg(stop - cur, ring_value[at(count - 1)], ST_SEGMENT);
        end
        if (s - 1 > 0) begin
          head = (head + s - 1) % Depth;
          count -= s - 1;
        end
        pending[$].last = 1'b1;
      end
    endfunction

    function void check_result(res_t r);
      res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", r);
        return;
      end
      e = pending.pop_front();
      if (r !== e) begin
        mismatches++;
        if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", e, r);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tvwb_stream_if #(.Width($bits(req_t))) in_ch ();
  tvwb_stream_if #(.Width($bits(res_t))) out_ch ();

  timestamped_value_window_buffer u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  window_scoreboard board = new();
  int hold_off = 0;
  int idle_cycles = 0;
  bit stall_mode = 1'b0;
  logic signed [TimeBits-1:0] last_time = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) board.check_result(res_t'(out_ch.data));
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_mode) begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles > 20000) begin
      $display("timestamped_value_window_buffer test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(req_t q);
    in_ch.valid <= 1'b1;
    in_ch.data <= q;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(q);
  endtask

  task automatic pause_input(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    pause_input(1);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_initial(logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {REG_INITIAL_VALUE, 1'b0};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.init_value = v;
  endtask

  function automatic req_t make(logic a, logic signed [31:0] t, logic [19:0] sp,
                                logic [31:0] v);
    req_t q;
    q.action = a;
    q.time_req = t;
    q.span = sp;
    q.value = v;
    return q;
  endfunction

  task automatic random_request();
    req_t q;
    int pick;
    pick = $urandom_range(0, 9);
    q.span = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'($urandom_range(0, 400));
    q.value = $urandom;
    if (pick < 5) begin
      q.action = 1'b0;
      if ($urandom_range(0, 9) == 0) q.time_req = $urandom;
      else if ($urandom_range(0, 5) == 0) q.time_req = last_time;
      else q.time_req = last_time + $urandom_range(1, 60);
      if ($urandom_range(0, 12) == 0) q.time_req = last_time - $urandom_range(1, 30);
      last_time = q.time_req;
    end else begin
      q.action = 1'b1;
      if ($urandom_range(0, 9) == 0) q.time_req = $urandom;
      else q.time_req = last_time - $urandom_range(0, 200);
    end
    send(q);
  endtask

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && n > 0) begin
        random_request();
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) pause_input($urandom_range(1, 12));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_initial(32'h8000_0000);
    send(make(1'b1, 32'sh8000_0000, 20'hFFFFF, 32'h0));
    send(make(1'b0, 32'sd100, 20'd0, 32'h7FFF_FFFF));
    send(make(1'b0, 32'sd100, 20'd5, 32'h1234_5678));
    send(make(1'b0, 32'sd90, 20'd0, 32'hFFFF_FFFF));
    send(make(1'b0, 32'sd200, 20'd0, 32'hA5A5_A5A5));
    send(make(1'b1, -32'sd50, 20'd300, 32'h0));
    send(make(1'b1, 32'sd95, 20'd0, 32'h0));
    send(make(1'b1, 32'sh7FFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF));
    send(make(1'b1, 32'sh8000_0000, 20'd10, 32'h0));
    for (int i = 0; i < 34; i++) send(make(1'b0, 32'sd300 + i, 20'd0, $urandom));
    send(make(1'b1, 32'sd330, 20'd2, 32'h0));
    last_time = 32'sd333;
    drain();
    stall_mode = 1'b1;
    write_initial(32'h7FFF_FFFF);
    random_phase(50);
    hold_off = 400;
    random_phase(20);
    drain();
    write_initial($urandom);
    stall_mode = 1'b0;
    random_phase(50);
    drain();
    write_initial(32'h0);
    stall_mode = 1'b1;
    random_phase(50);
    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("timestamped_value_window_buffer test passed");
    end else begin
      $display("timestamped_value_window_buffer test failed");
    end
    $finish;
  end
endmodule
